### sv/acsc_pkg.sv
// acsc_pkg: shared types and constants for the adc channel tag stream checker
// no dependencies; used by every module of the block by scoped names

package acsc_pkg;

    // field widths
    localparam int WORD_W  = 32;
    localparam int TAG_W   = 5;
    localparam int POS_W   = 5;
    localparam int CNT32_W = 32;
    localparam int CNT48_W = 48;

    // frame layout
    localparam logic [POS_W-1:0] POS_LAST         = 5'd31;
    localparam logic [POS_W-1:0] COUNTER_CHANNELS = 5'd24;
    localparam logic [POS_W-1:0] HUNT_TAGS        = 5'd4;
    localparam logic [POS_W-1:0] HUNT_LAST        = 5'd31;

    // saturation limits
    localparam logic [CNT32_W-1:0] MAX32 = {CNT32_W{1'b1}};
    localparam logic [CNT48_W-1:0] MAX48 = {CNT48_W{1'b1}};

    // per-item result codes
    typedef enum logic [3:0] {
        ST_TAG_OK    = 4'd0,
        ST_MISMATCH  = 4'd1,
        ST_DISCARDED = 4'd2,
        ST_HUNTING   = 4'd3,
        ST_REALIGNED = 4'd4,
        ST_SEQ_OK    = 4'd5,
        ST_SEQ_SKIP  = 4'd6,
        ST_FIRST     = 4'd7,
        ST_PAD       = 4'd8
    } status_t;

    // checker phase
    typedef enum logic [1:0] {
        PH_CHECK   = 2'd0,
        PH_DISCARD = 2'd1,
        PH_HUNT    = 2'd2
    } phase_t;

    // one result item
    typedef struct packed {
        status_t              status;
        logic [TAG_W-1:0]     expected_tag;
        logic [TAG_W-1:0]     received_tag;
        logic [CNT32_W-1:0]   tag_error_count;
        logic [CNT32_W-1:0]   sequence_error_count;
        logic [CNT48_W-1:0]   frames_seen;
        logic [CNT48_W-1:0]   words_checked;
        logic [CNT48_W-1:0]   words_since_error;
        logic [WORD_W-1:0]    last_sample;
    } result_t;

endpackage

### sv/adc_channel_tag_stream_checker.sv
// Checks a converter word stream arranged in 32-word frames: the low five bits of each word
// are a channel tag that must follow 0..31, or 0..23 plus a sample counter word and seven pad
// words when counter_mode is set. After a tag mismatch the rest of the frame is discarded and
// the checker hunts for tags 0,1,2,3, skips 28 more words and restarts at tag 0. Each input
// item gives exactly one result item carrying a status code, the expected and received tags
// and saturating error and word counts. An item passes through an input register and then a
// result register; one item is accepted every cycle, limited only by the output channel's
// ready. The user must write counter_mode only while the block is idle; the block itself
// does not enforce this. Depends on acsc_pkg, acsc_in_reg, acsc_core and acsc_out_reg.

module adc_channel_tag_stream_checker (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         cfg_write_en,
    input  logic                         cfg_write_data,
    input  logic                         in_valid,
    output logic                         in_ready,
    input  logic [acsc_pkg::WORD_W-1:0]  sample_word,
    output logic                         out_valid,
    input  logic                         out_ready,
    output logic [3:0]                   status,
    output logic [acsc_pkg::TAG_W-1:0]   expected_tag,
    output logic [acsc_pkg::TAG_W-1:0]   received_tag,
    output logic [acsc_pkg::CNT32_W-1:0] tag_error_count,
    output logic [acsc_pkg::CNT32_W-1:0] sequence_error_count,
    output logic [acsc_pkg::CNT48_W-1:0] frames_seen,
    output logic [acsc_pkg::CNT48_W-1:0] words_checked,
    output logic [acsc_pkg::CNT48_W-1:0] words_since_error,
    output logic [acsc_pkg::WORD_W-1:0]  last_sample
);

    logic                        counter_mode_reg;
    logic                        take;
    logic                        held_valid;
    logic [acsc_pkg::WORD_W-1:0] held_word;
    acsc_pkg::result_t           result;
    acsc_pkg::result_t           result_q;

    // mode register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            counter_mode_reg <= 1'b0;
        end
        else if (cfg_write_en)
        begin
            counter_mode_reg <= cfg_write_data;
        end
    end

    acsc_in_reg u_in_reg (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_ready    (in_ready),
        .sample_word (sample_word),
        .take        (take),
        .held_valid  (held_valid),
        .held_word   (held_word)
    );

    acsc_core u_core (
        .clk          (clk),
        .rst_n        (rst_n),
        .take         (take),
        .word         (held_word),
        .counter_mode (counter_mode_reg),
        .result       (result)
    );

    acsc_out_reg u_out_reg (
        .clk        (clk),
        .rst_n      (rst_n),
        .held_valid (held_valid),
        .take       (take),
        .result     (result),
        .out_valid  (out_valid),
        .out_ready  (out_ready),
        .result_q   (result_q)
    );

    // result fields
    assign status               = result_q.status;
    assign expected_tag         = result_q.expected_tag;
    assign received_tag         = result_q.received_tag;
    assign tag_error_count      = result_q.tag_error_count;
    assign sequence_error_count = result_q.sequence_error_count;
    assign frames_seen          = result_q.frames_seen;
    assign words_checked        = result_q.words_checked;
    assign words_since_error    = result_q.words_since_error;
    assign last_sample          = result_q.last_sample;

endmodule

### sv/acsc_in_reg.sv
// acsc_in_reg: input register for one converter word
// depends on acsc_pkg

module acsc_in_reg (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       in_valid,
    output logic                       in_ready,
    input  logic [acsc_pkg::WORD_W-1:0] sample_word,
    input  logic                       take,
    output logic                       held_valid,
    output logic [acsc_pkg::WORD_W-1:0] held_word
);

    logic                        valid_reg;
    logic                        valid_next;
    logic [acsc_pkg::WORD_W-1:0] word_reg;

    // slot frees up when the held item moves on this cycle
    assign in_ready   = !valid_reg || take;
    assign valid_next = (in_valid && in_ready) || (valid_reg && !take);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    // payload, no reset
    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            word_reg <= sample_word;
        end
    end

    assign held_valid = valid_reg;
    assign held_word  = word_reg;

endmodule

### sv/acsc_core.sv
// acsc_core: checker state and per-word decision logic
// depends on acsc_pkg; fed by acsc_in_reg, drives acsc_out_reg

module acsc_core (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        take,
    input  logic [acsc_pkg::WORD_W-1:0] word,
    input  logic                        counter_mode,
    output acsc_pkg::result_t           result
);

    acsc_pkg::phase_t                  phase_reg, phase_next;
    logic [acsc_pkg::POS_W-1:0]        pos_reg, pos_next;
    logic [acsc_pkg::TAG_W-1:0]        exp_reg, exp_next;
    logic [acsc_pkg::POS_W-1:0]        hunt_reg, hunt_next;
    logic [acsc_pkg::WORD_W-1:0]       prev_reg, prev_next;
    logic                              have_prev_reg, have_prev_next;
    logic [acsc_pkg::CNT32_W-1:0]      tag_err_reg, tag_err_next;
    logic [acsc_pkg::CNT32_W-1:0]      seq_err_reg, seq_err_next;
    logic [acsc_pkg::CNT48_W-1:0]      frames_reg, frames_next;
    logic [acsc_pkg::CNT48_W-1:0]      checked_reg, checked_next;
    logic [acsc_pkg::CNT48_W-1:0]      since_reg, since_next;

    logic [acsc_pkg::TAG_W-1:0]        tag;
    logic                              is_seq;
    logic                              is_pad;
    logic                              tag_match;
    logic                              pos_wrap;
    acsc_pkg::status_t                 status;
    logic [acsc_pkg::TAG_W-1:0]        exp_out;

    // word decode
    assign tag       = word[acsc_pkg::TAG_W-1:0];
    assign is_seq    = counter_mode && (pos_reg == acsc_pkg::COUNTER_CHANNELS);
    assign is_pad    = counter_mode && (pos_reg > acsc_pkg::COUNTER_CHANNELS);
    assign tag_match = (tag == exp_reg);
    assign pos_wrap  = (pos_reg == acsc_pkg::POS_LAST);

    // next phase
    always_comb
    begin
        phase_next = phase_reg;
        case (phase_reg)
            acsc_pkg::PH_HUNT:
            begin
                if (hunt_reg == acsc_pkg::HUNT_LAST)
                begin
                    phase_next = acsc_pkg::PH_CHECK;
                end
            end
            acsc_pkg::PH_DISCARD:
            begin
                if (pos_wrap)
                begin
                    phase_next = acsc_pkg::PH_HUNT;
                end
            end
            default:
            begin
                if (!is_seq && !is_pad && !tag_match)
                begin
                    phase_next = pos_wrap ? acsc_pkg::PH_HUNT : acsc_pkg::PH_DISCARD;
                end
            end
        endcase
    end

    // datapath updates and result fields
    always_comb
    begin
        pos_next       = pos_reg;
        exp_next       = exp_reg;
        hunt_next      = hunt_reg;
        prev_next      = prev_reg;
        have_prev_next = have_prev_reg;
        tag_err_next   = tag_err_reg;
        seq_err_next   = seq_err_reg;
        frames_next    = frames_reg;
        checked_next   = checked_reg;
        since_next     = since_reg;
        status         = acsc_pkg::ST_HUNTING;
        exp_out        = '0;
        case (phase_reg)
            acsc_pkg::PH_HUNT:
            begin
                if (hunt_reg < acsc_pkg::HUNT_TAGS)
                begin
                    exp_out   = hunt_reg;
                    hunt_next = (tag == hunt_reg) ? hunt_reg + 5'd1 : '0;
                end
                else if (hunt_reg == acsc_pkg::HUNT_LAST)
                begin
                    status    = acsc_pkg::ST_REALIGNED;
                    pos_next  = '0;
                    exp_next  = '0;
                    hunt_next = '0;
                end
                else
                begin
                    hunt_next = hunt_reg + 5'd1;
                end
            end
            acsc_pkg::PH_DISCARD:
            begin
                status   = acsc_pkg::ST_DISCARDED;
                pos_next = pos_reg + 5'd1;
                if (pos_wrap)
                begin
                    hunt_next = '0;
                end
            end
            default:
            begin
                pos_next = pos_reg + 5'd1;
                // frame start in counter mode
                if (counter_mode && (pos_reg == '0) && (frames_reg != acsc_pkg::MAX48))
                begin
                    frames_next = frames_reg + 48'd1;
                end
                if (is_seq)
                begin
                    if (!have_prev_reg)
                    begin
                        status = acsc_pkg::ST_FIRST;
                    end
                    else if (word == prev_reg + 32'd1)
                    begin
                        status = acsc_pkg::ST_SEQ_OK;
                    end
                    else
                    begin
                        status = acsc_pkg::ST_SEQ_SKIP;
                        if (seq_err_reg != acsc_pkg::MAX32)
                        begin
                            seq_err_next = seq_err_reg + 32'd1;
                        end
                    end
                    prev_next      = word;
                    have_prev_next = 1'b1;
                    exp_next       = '0;
                end
                else if (is_pad)
                begin
                    status = acsc_pkg::ST_PAD;
                end
                else if (tag_match)
                begin
                    status   = acsc_pkg::ST_TAG_OK;
                    exp_out  = exp_reg;
                    exp_next = exp_reg + 5'd1;
                    if (checked_reg != acsc_pkg::MAX48)
                    begin
                        checked_next = checked_reg + 48'd1;
                        since_next   = since_reg + 48'd1;
                    end
                end
                else
                begin
                    status     = acsc_pkg::ST_MISMATCH;
                    exp_out    = exp_reg;
                    exp_next   = '0;
                    since_next = '0;
                    hunt_next  = '0;
                    if (tag_err_reg != acsc_pkg::MAX32)
                    begin
                        tag_err_next = tag_err_reg + 32'd1;
                    end
                end
            end
        endcase
    end

    // state registers, advance once per item
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg     <= acsc_pkg::PH_CHECK;
            pos_reg       <= '0;
            exp_reg       <= '0;
            hunt_reg      <= '0;
            prev_reg      <= '0;
            have_prev_reg <= 1'b0;
            tag_err_reg   <= '0;
            seq_err_reg   <= '0;
            frames_reg    <= '0;
            checked_reg   <= '0;
            since_reg     <= '0;
        end
        else if (take)
        begin
            phase_reg     <= phase_next;
            pos_reg       <= pos_next;
            exp_reg       <= exp_next;
            hunt_reg      <= hunt_next;
            prev_reg      <= prev_next;
            have_prev_reg <= have_prev_next;
            tag_err_reg   <= tag_err_next;
            seq_err_reg   <= seq_err_next;
            frames_reg    <= frames_next;
            checked_reg   <= checked_next;
            since_reg     <= since_next;
        end
    end

    // result item, counts after this word's update
    always_comb
    begin
        result.status               = status;
        result.expected_tag         = exp_out;
        result.received_tag         = tag;
        result.tag_error_count      = tag_err_next;
        result.sequence_error_count = seq_err_next;
        result.frames_seen          = frames_next;
        result.words_checked        = checked_next;
        result.words_since_error    = since_next;
        result.last_sample          = prev_next;
    end

    // hunt counter only runs while hunting
    a_hunt_idle: assert property (@(posedge clk) disable iff (!rst_n)
        (phase_reg != acsc_pkg::PH_HUNT) |-> (hunt_reg == '0))
        else $error("hunt progress nonzero outside hunt");

    // a hunt always starts at a frame boundary
    a_hunt_pos: assert property (@(posedge clk) disable iff (!rst_n)
        (phase_reg == acsc_pkg::PH_HUNT) |-> (pos_reg == '0))
        else $error("frame position nonzero while hunting");

    // words since error never exceeds words checked
    a_since_bound: assert property (@(posedge clk) disable iff (!rst_n)
        since_reg <= checked_reg)
        else $error("words since error above words checked");

    // a mismatch resets the expected tag and leaves checking
    a_mismatch: assert property (@(posedge clk) disable iff (!rst_n)
        (take && (status == acsc_pkg::ST_MISMATCH))
        |=> ((exp_reg == '0) && (phase_reg != acsc_pkg::PH_CHECK)))
        else $error("mismatch did not leave checking");

    // discard ends only in a hunt
    a_discard_exit: assert property (@(posedge clk) disable iff (!rst_n)
        (take && (phase_reg == acsc_pkg::PH_DISCARD))
        |=> ((phase_reg == acsc_pkg::PH_DISCARD) || (phase_reg == acsc_pkg::PH_HUNT)))
        else $error("discard left to wrong phase");

endmodule

### sv/acsc_out_reg.sv
// acsc_out_reg: result register between the core and the output channel
// depends on acsc_pkg

module acsc_out_reg (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              held_valid,
    output logic              take,
    input  acsc_pkg::result_t result,
    output logic              out_valid,
    input  logic              out_ready,
    output acsc_pkg::result_t result_q
);

    logic              valid_reg;
    logic              valid_next;
    acsc_pkg::result_t data_reg;

    // move the held item on when the result slot is empty or draining
    assign take       = held_valid && (!valid_reg || out_ready);
    assign valid_next = take || (valid_reg && !out_ready);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    // payload, no reset
    always_ff @(posedge clk)
    begin
        if (take)
        begin
            data_reg <= result;
        end
    end

    assign out_valid = valid_reg;
    assign result_q  = data_reg;

endmodule
